// ===== sv/joystick_calibrated_servo_mapper_assert.svh =====
// ============================================================================
// Assertion macros for the joystick servo mapper
// Clocked, reset-qualified property shorthands shared by the checker.
// ============================================================================
`ifndef JOYSTICK_CALIBRATED_SERVO_MAPPER_ASSERT_SVH
`define JOYSTICK_CALIBRATED_SERVO_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define JCSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("jcsm: check failed");

// Next-cycle implication, disabled while reset is asserted
`define JCSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("jcsm: check failed");

`endif

// ===== sv/jcsm_pkg.sv =====
// ============================================================================
// jcsm_pkg
// Shared types, codes and widths of the joystick servo mapper.
// ============================================================================
package jcsm_pkg;

    localparam int DEBOUNCE_LEN_DEF = 10;

    localparam int SAMPLE_W = 10;
    localparam int PULSE_CFG_W = 12;
    localparam int CMP_W = 16;
    localparam int PHASE_W = 3;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // |pos - bottom| <= 1023, |pmax - pmin| <= 4095, product < 2^22
    localparam int MAG_A_W = SAMPLE_W;
    localparam int MAG_B_W = PULSE_CFG_W;
    localparam int PROD_W = MAG_A_W + MAG_B_W;
    localparam int PULSE_W = PROD_W + 2;
    localparam int DIFF_W = PULSE_W + 1;

    // Two bits per cycle in both the multiplier and the divider
    localparam int MUL_STEPS = MAG_A_W / 2;
    localparam int DIV_STEPS = PROD_W / 2;
    localparam int STEP_W = 4;

    localparam logic [CMP_W-1:0]       PERIOD_RST = 16'd4000;
    localparam logic [PULSE_CFG_W-1:0] PMIN_RST   = 12'd180;
    localparam logic [PULSE_CFG_W-1:0] PMAX_RST   = 12'd420;
    localparam logic [CMP_W-1:0]       INIT_CMP_RST = 16'd3700;
    localparam logic [SAMPLE_W-1:0]    TOP_RST    = 10'd300;
    localparam logic [SAMPLE_W-1:0]    BOTTOM_RST = 10'd1023;

    typedef enum logic [1:0] {
        REG_PERIOD   = 2'd0,
        REG_PULSE_MIN = 2'd1,
        REG_PULSE_MAX = 2'd2,
        REG_INIT_CMP = 2'd3
    } cfg_idx_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_X_TOP    = 3'd0,
        PH_X_BOTTOM = 3'd1,
        PH_Y_TOP    = 3'd2,
        PH_Y_BOTTOM = 3'd3,
        PH_X_LIVE   = 3'd4,
        PH_Y_LIVE   = 3'd5,
        PH_DONE     = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_MUL  = 3'd1,
        ST_DIV  = 3'd2,
        ST_SUM  = 3'd3,
        ST_FIN  = 3'd4
    } state_t;

endpackage

// ===== sv/joystick_calibrated_servo_mapper.sv =====
// ============================================================================
// joystick_calibrated_servo_mapper
// Debounced trigger walks a calibration sequence; live servo steps map the
// joystick sample onto a compare value with a serial multiply and divide.
// ============================================================================
// Sequence: a beat on a tick without a live servo goes from idle straight to the final
//   step; a live-servo beat passes the idle, multiply, divide, sum and final steps.
// Throughput: one beat in flight; no new beat is taken until the final step has
//   loaded the result register, and a stalled result register holds the final step.
// Reset: aresetn is synchronous, active low; it restores the register file,
//   calibration points and compare values and empties the result register.
module joystick_calibrated_servo_mapper #(
    parameter int DEBOUNCE_LEN = jcsm_pkg::DEBOUNCE_LEN_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input beats
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_trigger_level,
    input  logic [jcsm_pkg::SAMPLE_W-1:0]      s_x_sample,
    input  logic [jcsm_pkg::SAMPLE_W-1:0]      s_y_sample,
    // result beats
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [jcsm_pkg::PHASE_W-1:0]       m_phase,
    output logic                               m_click,
    output logic [jcsm_pkg::CMP_W-1:0]         m_x_compare,
    output logic [jcsm_pkg::CMP_W-1:0]         m_y_compare,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [jcsm_pkg::ADDR_W-1:0]        paddr,
    input  logic [jcsm_pkg::DATA_W-1:0]        pwdata,
    output logic [jcsm_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);

    // Debounce counter just wide enough to count one block
    localparam int CNT_W = (DEBOUNCE_LEN > 1) ? $clog2(DEBOUNCE_LEN) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DEBOUNCE_LEN - 1);

    localparam int SW  = jcsm_pkg::SAMPLE_W;
    localparam int PW  = jcsm_pkg::PULSE_CFG_W;
    localparam int CW  = jcsm_pkg::CMP_W;
    localparam int XW  = jcsm_pkg::PROD_W;
    localparam int AW  = jcsm_pkg::MAG_A_W;
    localparam int BW  = jcsm_pkg::MAG_B_W;
    localparam int UW  = jcsm_pkg::PULSE_W;
    localparam int DW  = jcsm_pkg::DIFF_W;
    localparam int TW  = jcsm_pkg::STEP_W;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [CW-1:0] period_reg;
    logic [PW-1:0] pmin_reg;
    logic [PW-1:0] pmax_reg;
    logic [CW-1:0] init_cmp_reg;

    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    // Read mux: registers sit on 4-byte boundaries
    always_comb begin
        prdata = '0;
        case (jcsm_pkg::cfg_idx_t'(paddr[3:2]))
            jcsm_pkg::REG_PERIOD:    prdata = {{(jcsm_pkg::DATA_W-CW){1'b0}}, period_reg};
            jcsm_pkg::REG_PULSE_MIN: prdata = {{(jcsm_pkg::DATA_W-PW){1'b0}}, pmin_reg};
            jcsm_pkg::REG_PULSE_MAX: prdata = {{(jcsm_pkg::DATA_W-PW){1'b0}}, pmax_reg};
            jcsm_pkg::REG_INIT_CMP:  prdata = {{(jcsm_pkg::DATA_W-CW){1'b0}}, init_cmp_reg};
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    jcsm_pkg::state_t state_reg, state_next;
    logic [TW-1:0]    step_reg, step_next;

    jcsm_pkg::phase_t phase_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             any_high_reg;
    logic             armed_reg;
    logic             click_reg;

    // Marks a beat that went through the multiply/divide path
    logic             arith_done_reg;

    logic [SW-1:0] x_top_reg, x_bottom_reg, y_top_reg, y_bottom_reg;
    logic [CW-1:0] x_cmp_reg, y_cmp_reg;

    // Serial arithmetic datapath
    logic [XW-1:0]  acc_reg;       // product, then dividend/quotient
    logic [XW-1:0]  mcand_reg;     // |pmax - pmin|, shifted left per step
    logic [AW-1:0]  mplier_reg;    // |pos - bottom|, shifted right per step
    logic [SW-1:0]  div_reg;       // |top - bottom|
    logic [SW-1:0]  rem_reg;
    logic           neg_reg;
    logic           zspan_reg;
    logic           sel_y_reg;
    logic signed [UW-1:0] pulse_reg;

    logic in_beat, out_free, live;
    assign in_beat  = s_valid & s_ready;
    assign out_free = ~m_valid | m_ready;
    assign live     = (phase_reg == jcsm_pkg::PH_X_LIVE) ||
                      (phase_reg == jcsm_pkg::PH_Y_LIVE);

    // ------------------------------------------------------------------
    // Sequencer: next state and handshake
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jcsm_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        case (state_reg)
            jcsm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                step_next = '0;
                // Only a live servo step needs the arithmetic
                if (s_valid) begin
                    state_next = live ? jcsm_pkg::ST_MUL : jcsm_pkg::ST_FIN;
                end
            end
            jcsm_pkg::ST_MUL: begin
                if (step_reg == TW'(jcsm_pkg::MUL_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = jcsm_pkg::ST_DIV;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            jcsm_pkg::ST_DIV: begin
                if (step_reg == TW'(jcsm_pkg::DIV_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = jcsm_pkg::ST_SUM;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            jcsm_pkg::ST_SUM: begin
                state_next = jcsm_pkg::ST_FIN;
            end
            jcsm_pkg::ST_FIN: begin
                // Hold until the result register is free
                if (out_free) begin
                    state_next = jcsm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = jcsm_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Operand setup at the input beat (signed differences -> magnitudes)
    // ------------------------------------------------------------------
    logic [SW-1:0]   pos_w, bot_w, top_w;
    logic [SW:0]     a_w, span_w, a_mag_w, span_mag_w;
    logic [PW:0]     b_w, b_mag_w;

    always_comb begin
        pos_w = (phase_reg == jcsm_pkg::PH_Y_LIVE) ? s_y_sample   : s_x_sample;
        bot_w = (phase_reg == jcsm_pkg::PH_Y_LIVE) ? y_bottom_reg : x_bottom_reg;
        top_w = (phase_reg == jcsm_pkg::PH_Y_LIVE) ? y_top_reg    : x_top_reg;
        a_w    = {1'b0, pos_w} - {1'b0, bot_w};
        span_w = {1'b0, top_w} - {1'b0, bot_w};
        b_w    = {1'b0, pmax_reg} - {1'b0, pmin_reg};
        a_mag_w    = a_w[SW]    ? (~a_w + 1'b1)    : a_w;
        span_mag_w = span_w[SW] ? (~span_w + 1'b1) : span_w;
        b_mag_w    = b_w[PW]    ? (~b_w + 1'b1)    : b_w;
    end

    // ------------------------------------------------------------------
    // One multiply step: two multiplier bits, LSB first
    // ------------------------------------------------------------------
    logic [XW-1:0] mul_w;
    always_comb begin
        mul_w = acc_reg
              + (mplier_reg[0] ? mcand_reg : '0)
              + (mplier_reg[1] ? {mcand_reg[XW-2:0], 1'b0} : '0);
    end

    // ------------------------------------------------------------------
    // One divide step: two restoring iterations; the quotient shifts into
    // the low end of the dividend register as the dividend leaves the top
    // ------------------------------------------------------------------
    logic [SW-1:0] rem_w;
    logic [XW-1:0] quo_w;
    logic [SW:0]   trial_w;
    always_comb begin
        rem_w   = rem_reg;
        quo_w   = acc_reg;
        trial_w = '0;
        for (int i = 0; i < 2; i++) begin
            trial_w = {rem_w, quo_w[XW-1]};
            quo_w   = {quo_w[XW-2:0], 1'b0};
            if (trial_w >= {1'b0, div_reg}) begin
                trial_w  = trial_w - {1'b0, div_reg};
                quo_w[0] = 1'b1;
            end
            rem_w = trial_w[SW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pulse and compare: pulse = pmin +/- quotient, compare = period - pulse
    // ------------------------------------------------------------------
    logic signed [UW-1:0] q_s_w, pulse_w;
    logic signed [DW-1:0] diff_w;
    logic [CW-1:0]        cmp_w;

    always_comb begin
        q_s_w   = $signed({{(UW-XW){1'b0}}, acc_reg});
        if (zspan_reg) begin
            q_s_w = '0;
        end else if (neg_reg) begin
            q_s_w = -q_s_w;
        end
        pulse_w = $signed({{(UW-PW){1'b0}}, pmin_reg}) + q_s_w;
        diff_w  = $signed({{(DW-CW){1'b0}}, period_reg}) - DW'(pulse_reg);
        // Saturate to the compare register's range
        if (diff_w[DW-1]) begin
            cmp_w = '0;
        end else if (|diff_w[DW-2:CW]) begin
            cmp_w = '1;
        end else begin
            cmp_w = diff_w[CW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            jcsm_pkg::ST_IDLE: begin
                if (in_beat) begin
                    acc_reg    <= '0;
                    mcand_reg  <= XW'(b_mag_w[BW-1:0]);
                    mplier_reg <= a_mag_w[AW-1:0];
                    div_reg    <= span_mag_w[SW-1:0];
                    rem_reg    <= '0;
                    neg_reg    <= a_w[SW] ^ b_w[PW] ^ span_w[SW];
                    zspan_reg  <= (span_w == '0);
                    sel_y_reg  <= (phase_reg == jcsm_pkg::PH_Y_LIVE);
                end
            end
            jcsm_pkg::ST_MUL: begin
                acc_reg    <= mul_w;
                mcand_reg  <= {mcand_reg[XW-3:0], 2'b00};
                mplier_reg <= {2'b00, mplier_reg[AW-1:2]};
            end
            jcsm_pkg::ST_DIV: begin
                acc_reg <= quo_w;
                rem_reg <= rem_w;
            end
            jcsm_pkg::ST_SUM: begin
                pulse_reg <= pulse_w;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Register file, debounce, calibration and compare state
    // ------------------------------------------------------------------
    logic block_end_w, any_w, pressed_w, click_w;
    assign block_end_w = (cnt_reg == CNT_LAST);
    assign any_w       = any_high_reg | s_trigger_level;
    assign pressed_w   = ~any_w;
    assign click_w     = block_end_w & pressed_w & armed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= jcsm_pkg::PERIOD_RST;
            pmin_reg     <= jcsm_pkg::PMIN_RST;
            pmax_reg     <= jcsm_pkg::PMAX_RST;
            init_cmp_reg <= jcsm_pkg::INIT_CMP_RST;
            phase_reg    <= jcsm_pkg::PH_X_TOP;
            cnt_reg      <= '0;
            any_high_reg <= 1'b0;
            armed_reg    <= 1'b0;
            click_reg    <= 1'b0;
            x_top_reg    <= jcsm_pkg::TOP_RST;
            x_bottom_reg <= jcsm_pkg::BOTTOM_RST;
            y_top_reg    <= jcsm_pkg::TOP_RST;
            y_bottom_reg <= jcsm_pkg::BOTTOM_RST;
            x_cmp_reg    <= jcsm_pkg::INIT_CMP_RST;
            y_cmp_reg    <= jcsm_pkg::INIT_CMP_RST;
        end else begin
            // The user must write registers only while no beat is in flight; the block does not enforce it
            if (cfg_wr) begin
                case (jcsm_pkg::cfg_idx_t'(paddr[3:2]))
                    jcsm_pkg::REG_PERIOD:    period_reg <= pwdata[CW-1:0];
                    jcsm_pkg::REG_PULSE_MIN: pmin_reg   <= pwdata[PW-1:0];
                    jcsm_pkg::REG_PULSE_MAX: pmax_reg   <= pwdata[PW-1:0];
                    jcsm_pkg::REG_INIT_CMP: begin
                        init_cmp_reg <= pwdata[CW-1:0];
                        // Reload any servo that is not driven yet
                        if (phase_reg < jcsm_pkg::PH_X_LIVE) begin
                            x_cmp_reg <= pwdata[CW-1:0];
                        end
                        if (phase_reg < jcsm_pkg::PH_Y_LIVE) begin
                            y_cmp_reg <= pwdata[CW-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // Debounce and phase advance at the input beat; the servo
            // selection was already captured from the phase before this beat
            if (in_beat) begin
                click_reg <= click_w;
                if (block_end_w) begin
                    cnt_reg      <= '0;
                    any_high_reg <= 1'b0;
                    if (!pressed_w) begin
                        armed_reg <= 1'b1;
                    end
                    if (click_w) begin
                        armed_reg <= 1'b0;
                        case (phase_reg)
                            jcsm_pkg::PH_X_TOP: begin
                                x_top_reg <= s_x_sample;
                                phase_reg <= jcsm_pkg::PH_X_BOTTOM;
                            end
                            jcsm_pkg::PH_X_BOTTOM: begin
                                x_bottom_reg <= s_x_sample;
                                phase_reg    <= jcsm_pkg::PH_Y_TOP;
                            end
                            jcsm_pkg::PH_Y_TOP: begin
                                y_top_reg <= s_y_sample;
                                phase_reg <= jcsm_pkg::PH_Y_BOTTOM;
                            end
                            jcsm_pkg::PH_Y_BOTTOM: begin
                                y_bottom_reg <= s_y_sample;
                                phase_reg    <= jcsm_pkg::PH_X_LIVE;
                            end
                            jcsm_pkg::PH_X_LIVE: phase_reg <= jcsm_pkg::PH_Y_LIVE;
                            jcsm_pkg::PH_Y_LIVE: phase_reg <= jcsm_pkg::PH_DONE;
                            default: begin
                                // done: stay
                            end
                        endcase
                    end
                end else begin
                    cnt_reg      <= cnt_reg + 1'b1;
                    any_high_reg <= any_w;
                end
            end

            // Commit the new compare value once the arithmetic is done
            if (state_reg == jcsm_pkg::ST_SUM) begin
                // nothing: pulse registers this cycle
            end
            if ((state_reg == jcsm_pkg::ST_FIN) && out_free && (step_reg == '0)
                    && arith_done_reg) begin
                if (sel_y_reg) begin
                    y_cmp_reg <= cmp_w;
                end else begin
                    x_cmp_reg <= cmp_w;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arith_done_reg <= 1'b0;
        end else if (state_reg == jcsm_pkg::ST_SUM) begin
            arith_done_reg <= 1'b1;
        end else if (state_reg == jcsm_pkg::ST_FIN && out_free) begin
            arith_done_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result register: loads in the final step, holds while stalled
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if ((state_reg == jcsm_pkg::ST_FIN) && out_free) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == jcsm_pkg::ST_FIN) && out_free) begin
            m_phase     <= phase_reg;
            m_click     <= click_reg;
            m_x_compare <= (arith_done_reg && !sel_y_reg) ? cmp_w : x_cmp_reg;
            m_y_compare <= (arith_done_reg &&  sel_y_reg) ? cmp_w : y_cmp_reg;
        end
    end

endmodule

// ===== sv/jcsm_checker.sv =====
// ============================================================================
// jcsm_checker
// Port-level checks on the joystick servo mapper, bound to the top level.
// ============================================================================
`include "joystick_calibrated_servo_mapper_assert.svh"

module jcsm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [jcsm_pkg::PHASE_W-1:0]   m_phase,
    input logic [jcsm_pkg::CMP_W-1:0]     m_x_compare,
    input logic [jcsm_pkg::CMP_W-1:0]     m_y_compare
);

    // A stalled result beat holds its payload
    `JCSM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_x_compare) && $stable(m_y_compare) && $stable(m_phase))

    // The unused phase code never shows up
    `JCSM_ASSERT_NOW(a_phase_range, m_valid, m_phase <= jcsm_pkg::PH_DONE)

    // One beat at a time: input side closes right after a beat is taken
    `JCSM_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready)

    // A live servo beat cannot finish in the next cycle
    `JCSM_ASSERT_NEXT(a_no_early_result, s_valid && s_ready && !m_valid && !$past(m_valid), !m_valid || (m_phase < jcsm_pkg::PH_X_LIVE))

endmodule

bind joystick_calibrated_servo_mapper jcsm_checker u_jcsm_checker (.*);
